// ===== rtl/jsd_pkg.sv =====
// Shared types and constants for the JEF stitch stream decoder.
package jsd_pkg;

  localparam logic [7:0] ESC_BYTE = 8'h80;
  localparam logic [7:0] END_CODE = 8'h10;
  localparam logic [7:0] TRIM_A   = 8'h02;
  localparam logic [7:0] TRIM_B   = 8'h04;
  localparam logic [7:0] TRIM_C   = 8'h06;

  localparam int LIMIT_WIDTH = 24;
  localparam int CMP_WIDTH   = 33;
  localparam int OUT_DEPTH   = 4;
  localparam int OUT_PTR_W   = 2;
  localparam int OUT_CNT_W   = 3;

  typedef enum logic [1:0] {
    KIND_NORMAL = 2'd0,
    KIND_STOP   = 2'd1,
    KIND_TRIM   = 2'd2,
    KIND_END    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_FIRST     = 2'd0,
    PH_SECOND    = 2'd1,
    PH_ESC_FIRST = 2'd2,
    PH_ESC_SECOND = 2'd3
  } phase_t;

  typedef struct packed {
    logic signed [7:0] dx;
    logic signed [7:0] dy;
    kind_t             kind;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } emit_t;

endpackage

// ===== rtl/jef_stitch_stream_decoder_core.sv =====
// JEF stitch stream decoder top level: byte stream in, stitch stream out.
// One byte is taken per clock while the four-entry result queue has room for
// two stitches; a byte yields no stitch, one, or (when the pair limit runs
// out) a stitch plus an end stitch. While m_axis_tready is high, one stitch
// drains per clock; a byte per cycle goes in. The user must set pair_limit
// on always-ready cfg only while the stream is idle; nothing enforces it.
module jef_stitch_stream_decoder_core import jsd_pkg::*; #(
  parameter int COUNT_WIDTH = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] first_of_file
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] dx, [15:8] dy
  output logic [1:0]  m_axis_tuser,   // [1:0] stitch_kind
  output logic        m_axis_tlast,   // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data        // [23:0] pair_limit
);

  logic [LIMIT_WIDTH-1:0] pair_limit;
  logic                   take, pop, room;
  emit_t                  emit;
  result_t                head;
  logic [OUT_CNT_W-1:0]   level;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = room;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign pop           = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_limit <= LIMIT_WIDTH'(1);
    end else if (cfg_valid && cfg_ready) begin
      pair_limit <= cfg_data;
    end
  end

  jsd_parser #(.COUNT_WIDTH(COUNT_WIDTH)) u_parser (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .data_byte    (s_axis_tdata),
    .first_of_file(s_axis_tuser),
    .pair_limit   (pair_limit),
    .emit         (emit)
  );

  jsd_out_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .emit     (emit),
    .pop      (pop),
    .head     (head),
    .not_empty(m_axis_tvalid),
    .room     (room),
    .level    (level)
  );

  assign m_axis_tdata = {head.dy, head.dx};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= OUT_CNT_W'(OUT_DEPTH))
    else $error("result queue overflow");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == KIND_END |-> m_axis_tlast)
    else $error("end stitch not marked last");

  a_no_emit_stalled: assert property (@(posedge clk) disable iff (rst)
    !take |-> emit.count == 2'd0)
    else $error("stitch emitted without an accepted byte");

  a_pair_then_end: assert property (@(posedge clk) disable iff (rst)
    emit.count == 2'd2 |-> emit.r1.kind == KIND_END && !emit.r0.last)
    else $error("two-stitch burst malformed");

endmodule

// ===== rtl/jsd_parser.sv =====
// Byte-pair parser: parse state and decode of one byte into up to two stitches.
module jsd_parser import jsd_pkg::*; #(
  parameter int COUNT_WIDTH = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  logic [7:0]             data_byte,
  input  logic                   first_of_file,
  input  logic [LIMIT_WIDTH-1:0] pair_limit,
  output emit_t                  emit
);

  localparam logic [COUNT_WIDTH-1:0] SEEN_TOP = '1;

  phase_t                 phase, phase_next;
  logic [7:0]             held, held_next;
  kind_t                  pend, pend_next;
  logic [COUNT_WIDTH-1:0] seen, seen_next;
  logic                   finished, finished_next;

  // state as seen after an optional restart
  phase_t                 ph_e;
  logic [7:0]             held_e;
  kind_t                  pend_e;
  logic [COUNT_WIDTH-1:0] seen_e, seen_inc;
  logic                   fin_e;
  logic                   at_limit, inc_at_limit;
  logic                   is_esc, esc_stop, esc_trim, esc_end;

  assign ph_e   = first_of_file ? PH_FIRST : phase;
  assign held_e = first_of_file ? 8'h00 : held;
  assign pend_e = first_of_file ? KIND_NORMAL : pend;
  assign seen_e = first_of_file ? '0 : seen;
  assign fin_e  = first_of_file ? 1'b0 : finished;

  assign seen_inc     = (seen_e == SEEN_TOP) ? seen_e : seen_e + 1'b1;
  assign at_limit     = CMP_WIDTH'(seen_e) >= CMP_WIDTH'(pair_limit);
  assign inc_at_limit = CMP_WIDTH'(seen_inc) >= CMP_WIDTH'(pair_limit);

  assign is_esc   = held_e == ESC_BYTE;
  assign esc_stop = is_esc && data_byte[0];
  assign esc_trim = is_esc && (data_byte == TRIM_A || data_byte == TRIM_B ||
                               data_byte == TRIM_C);
  assign esc_end  = is_esc && data_byte == END_CODE;

  always_comb begin
    phase_next = ph_e;
    if (!fin_e) begin
      unique case (ph_e)
        PH_FIRST:      phase_next = at_limit ? PH_FIRST : PH_SECOND;
        PH_SECOND:     phase_next = (esc_stop || esc_trim) ? PH_ESC_FIRST : PH_FIRST;
        PH_ESC_FIRST:  phase_next = PH_ESC_SECOND;
        PH_ESC_SECOND: phase_next = PH_FIRST;
        default:       phase_next = PH_FIRST;
      endcase
    end
  end

  always_comb begin
    held_next     = held_e;
    pend_next     = pend_e;
    seen_next     = seen_e;
    finished_next = fin_e;
    emit          = '0;
    if (!fin_e) begin
      unique case (ph_e)
        PH_FIRST: begin
          if (at_limit) begin
            emit.count    = 2'd1;
            emit.r0       = '{dx: 8'sd0, dy: 8'sd0, kind: KIND_END, last: 1'b1};
            finished_next = 1'b1;
          end else begin
            held_next = data_byte;
          end
        end
        PH_ESC_FIRST: held_next = data_byte;
        default: begin
          seen_next = seen_inc;
          if (ph_e == PH_SECOND && esc_stop) begin
            pend_next = KIND_STOP;
          end else if (ph_e == PH_SECOND && esc_trim) begin
            pend_next = KIND_TRIM;
          end else if (ph_e == PH_SECOND && esc_end) begin
            emit.count    = 2'd1;
            emit.r0       = '{dx: 8'sd0, dy: 8'sd0, kind: KIND_END, last: 1'b1};
            finished_next = 1'b1;
          end else begin
            pend_next = KIND_NORMAL;
            emit.r0   = '{dx: held_e, dy: data_byte,
                          kind: (ph_e == PH_ESC_SECOND) ? pend_e : KIND_NORMAL,
                          last: !inc_at_limit};
            emit.r1   = '{dx: 8'sd0, dy: 8'sd0, kind: KIND_END, last: 1'b1};
            if (inc_at_limit) begin
              emit.count    = 2'd2;
              finished_next = 1'b1;
            end else begin
              emit.count = 2'd1;
            end
          end
        end
      endcase
    end
    if (!take) begin
      emit.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_FIRST;
      held     <= 8'h00;
      pend     <= KIND_NORMAL;
      seen     <= '0;
      finished <= 1'b0;
    end else if (take) begin
      phase    <= phase_next;
      held     <= held_next;
      pend     <= pend_next;
      seen     <= seen_next;
      finished <= finished_next;
    end
  end

endmodule

// ===== rtl/jsd_out_queue.sv =====
// Result queue: takes up to two stitches per cycle, hands out one per cycle.
module jsd_out_queue import jsd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  emit_t                emit,
  input  logic                 pop,
  output result_t              head,
  output logic                 not_empty,
  output logic                 room,
  output logic [OUT_CNT_W-1:0] level
);

  result_t                slots [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [OUT_CNT_W-1:0]   count, count_next;
  logic [OUT_PTR_W-1:0]   wr_ptr_1;

  assign wr_ptr_1   = wr_ptr + 1'b1;
  assign head       = slots[rd_ptr];
  assign not_empty  = count != '0;
  assign room       = count <= OUT_CNT_W'(OUT_DEPTH - 2);
  assign level      = count;
  assign count_next = count + OUT_CNT_W'(emit.count) - OUT_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (emit.count != 2'd0) begin
      slots[wr_ptr] <= emit.r0;
    end
    if (emit.count == 2'd2) begin
      slots[wr_ptr_1] <= emit.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OUT_PTR_W'(emit.count);
      rd_ptr <= rd_ptr + OUT_PTR_W'(pop);
      count  <= count_next;
    end
  end

endmodule

// ===== tb/tb_jef_stitch_stream_decoder_core.sv =====
// Testbench for the JEF stitch decoder: table-driven bytes, then random stitch streams.
module tb_jef_stitch_stream_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;
  import jsd_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int STALL_LIMIT  = 4000;
  localparam int SETTLE       = 16;
  localparam int RANDOM_BYTES = 700;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] data_byte
  logic        s_axis_tuser;   // [0] first_of_file
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [7:0] dx, [15:8] dy
  logic [1:0]  m_axis_tuser;   // [1:0] stitch_kind
  logic        m_axis_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [23:0] cfg_data;       // [23:0] pair_limit

  jef_stitch_stream_decoder_core DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  typedef struct packed {
    logic        is_cfg;
    logic [23:0] limit;
    logic [7:0]  b;
    logic        first;
    logic        typed;
    logic [1:0]  n;
    result_t     e0;
    result_t     e1;
  } plan_row_t;

  // decoder shadow state
  logic [23:0] pair_limit_m;
  logic [23:0] pairs_seen_m;
  phase_t      phase_m;
  logic [7:0]  held_m;
  kind_t       pend_m;
  logic        done_m;

  result_t     stitch_q[$];
  plan_row_t   plan[$];
  int          fails;
  int          useful_bytes;
  int          stall_cycles;
  bit          burst;
  logic        start_flag;
  logic        row_typed;
  logic [1:0]  row_n;
  result_t     row_e0;
  result_t     row_e1;
  int          rdy_hold;
  int          rdy_pick;

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic result_t stitch(input int dx, input int dy, input kind_t k,
                                     input logic l);
    result_t r;
    r.dx   = dx[7:0];
    r.dy   = dy[7:0];
    r.kind = k;
    r.last = l;
    return r;
  endfunction

  function automatic void clear_parse_m();
    phase_m      = PH_FIRST;
    held_m       = 8'h00;
    pend_m       = KIND_NORMAL;
    pairs_seen_m = '0;
    done_m       = 1'b0;
  endfunction

  function automatic void emit(input result_t r, input logic keep);
    if (keep) stitch_q.push_back(r);
  endfunction

  function automatic void close_word(input logic [7:0] x, input logic [7:0] y,
                                     input kind_t k, input logic keep);
    phase_m = PH_FIRST;
    if (pairs_seen_m >= pair_limit_m) begin
      emit(stitch(x, y, k, 1'b0), keep);
      emit(stitch(0, 0, KIND_END, 1'b1), keep);
      done_m = 1'b1;
    end else begin
      emit(stitch(x, y, k, 1'b1), keep);
    end
  endfunction

  // advance the shadow decoder by one byte; keep=0 updates state only
  function automatic void decode_byte(input logic [7:0] b, input logic first,
                                      input logic keep);
    kind_t k;
    if (first) clear_parse_m();
    if (done_m) return;
    useful_bytes++;
    case (phase_m)
      PH_FIRST: begin
        if (pairs_seen_m >= pair_limit_m) begin
          emit(stitch(0, 0, KIND_END, 1'b1), keep);
          done_m = 1'b1;
        end else begin
          held_m  = b;
          phase_m = PH_SECOND;
        end
      end
      PH_SECOND: begin
        if (pairs_seen_m != '1) pairs_seen_m = pairs_seen_m + 1'b1;
        if (held_m == ESC_BYTE && b[0]) begin
          pend_m  = KIND_STOP;
          phase_m = PH_ESC_FIRST;
        end else if (held_m == ESC_BYTE && (b == TRIM_A || b == TRIM_B || b == TRIM_C)) begin
          pend_m  = KIND_TRIM;
          phase_m = PH_ESC_FIRST;
        end else if (held_m == ESC_BYTE && b == END_CODE) begin
          emit(stitch(0, 0, KIND_END, 1'b1), keep);
          done_m  = 1'b1;
          phase_m = PH_FIRST;
        end else begin
          close_word(held_m, b, KIND_NORMAL, keep);
        end
      end
      PH_ESC_FIRST: begin
        held_m  = b;
        phase_m = PH_ESC_SECOND;
      end
      default: begin
        if (pairs_seen_m != '1) pairs_seen_m = pairs_seen_m + 1'b1;
        k      = pend_m;
        pend_m = KIND_NORMAL;
        close_word(held_m, b, k, keep);
      end
    endcase
  endfunction

  function automatic void check_stitch();
    result_t got;
    result_t want;
    got.dx   = m_axis_tdata[7:0];
    got.dy   = m_axis_tdata[15:8];
    got.kind = kind_t'(m_axis_tuser);
    got.last = m_axis_tlast;
    if (stitch_q.size() == 0) begin
      $display("%0t: unexpected stitch dx=%0d dy=%0d kind=%0d last=%0b",
               $time, got.dx, got.dy, got.kind, got.last);
      fails++;
      return;
    end
    want = stitch_q.pop_front();
    if (got.dx !== want.dx) begin
      $display("%0t: dx expected %0d got %0d", $time, want.dx, got.dx);
      fails++;
    end
    if (got.dy !== want.dy) begin
      $display("%0t: dy expected %0d got %0d", $time, want.dy, got.dy);
      fails++;
    end
    if (got.kind !== want.kind) begin
      $display("%0t: kind expected %0d got %0d", $time, want.kind, got.kind);
      fails++;
    end
    if (got.last !== want.last) begin
      $display("%0t: last expected %0b got %0b", $time, want.last, got.last);
      fails++;
    end
  endfunction

  // handshakes, prediction, checking and watchdog, all on the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if ((cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
          (m_axis_tvalid && m_axis_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (cfg_valid && cfg_ready) pair_limit_m = cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        decode_byte(s_axis_tdata, s_axis_tuser, !row_typed);
        if (row_typed && row_n > 0) stitch_q.push_back(row_e0);
        if (row_typed && row_n > 1) stitch_q.push_back(row_e1);
      end
      if (m_axis_tvalid && m_axis_tready) check_stitch();
      if (stall_cycles >= STALL_LIMIT) begin
        $display("jef_stitch_stream_decoder_core test failed");
        $finish;
      end
    end
  end

  // output back-pressure: short stalls mostly, some long, some open stretches
  always @(negedge clk) begin
    if (rdy_hold == 0) begin
      rdy_pick = $urandom_range(0, 99);
      if (rdy_pick < 50) begin
        m_axis_tready = 1'b1;
        rdy_hold = $urandom_range(1, 12);
      end else if (rdy_pick < 85) begin
        m_axis_tready = 1'b0;
        rdy_hold = $urandom_range(1, 3);
      end else if (rdy_pick < 95) begin
        m_axis_tready = 1'b1;
        rdy_hold = $urandom_range(30, 80);
      end else begin
        m_axis_tready = 1'b0;
        rdy_hold = $urandom_range(15, 50);
      end
    end else begin
      rdy_hold = rdy_hold - 1;
    end
  end

  function automatic int pick_gap();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // called at a falling edge; returns at the falling edge after the byte is taken
  task automatic send_byte(input logic [7:0] b, input logic first);
    int g;
    g = pick_gap();
    if (g > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (g) @(negedge clk);
    end
    s_axis_tdata  = b;
    s_axis_tuser  = first;
    s_axis_tvalid = 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic feed(input logic [7:0] b);
    send_byte(b, start_flag);
    start_flag = 1'b0;
  endtask

  // waits for the decoder to go quiet before touching pair_limit
  task automatic set_limit(input logic [23:0] v);
    s_axis_tvalid = 1'b0;
    while (stitch_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_data  = v;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [23:0] pick_limit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 24'd0;
    if (r < 18) return 24'd1;
    if (r < 24) return 24'hFFFFFF;
    if (r < 34) return 24'($urandom);
    return 24'($urandom_range(2, 25));
  endfunction

  // one stitch section: mostly plain words; escapes, noise, restarts, limits, end codes
  task automatic run_stream();
    int words;
    int r;
    logic [7:0] code;
    if ($urandom_range(0, 3) == 0) set_limit(pick_limit());
    burst = ($urandom_range(0, 4) == 0);
    words = $urandom_range(1, 30);
    start_flag = 1'b1;
    for (int w = 0; w < words; w++) begin
      if (done_m && !start_flag) break;
      r = $urandom_range(0, 99);
      if (r < 62) begin
        feed(8'($urandom));
        feed(8'($urandom));
      end else if (r < 78) begin
        if ($urandom_range(0, 1) == 1) code = 8'($urandom_range(0, 127) * 2 + 1);
        else code = 8'($urandom_range(1, 3) * 2);
        feed(ESC_BYTE);
        feed(code);
        feed(8'($urandom));
        feed(8'($urandom));
      end else if (r < 85) begin
        code = 8'($urandom_range(0, 127) * 2);
        if (code == TRIM_A || code == TRIM_B || code == TRIM_C || code == END_CODE)
          code = 8'h08;
        feed(ESC_BYTE);
        feed(code);
      end else if (r < 91) begin
        start_flag = start_flag | ($urandom_range(0, 7) == 0);
        feed(8'($urandom));
      end else if (r < 96) begin
        if (phase_m == PH_FIRST) set_limit(24'($urandom_range(0, pairs_seen_m + 2)));
      end else begin
        feed(ESC_BYTE);
        feed(END_CODE);
      end
    end
    repeat ($urandom_range(0, 2)) feed(8'($urandom));
  endtask

  task automatic add_cfg(input logic [23:0] v);
    plan_row_t p;
    p = '0;
    p.is_cfg = 1'b1;
    p.limit  = v;
    plan.push_back(p);
  endtask

  task automatic add_byte(input logic [7:0] b, input logic first);
    plan_row_t p;
    p = '0;
    p.b     = b;
    p.first = first;
    plan.push_back(p);
  endtask

  task automatic add_typed(input logic [7:0] b, input logic first, input logic [1:0] n,
                           input result_t e0, input result_t e1);
    plan_row_t p;
    p = '0;
    p.b     = b;
    p.first = first;
    p.typed = 1'b1;
    p.n     = n;
    p.e0    = e0;
    p.e1    = e1;
    plan.push_back(p);
  endtask

  initial begin
    result_t none;
    result_t fin;
    int mark;
    clk = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = 24'd0;
    fails = 0;
    useful_bytes = 0;
    stall_cycles = 0;
    burst = 1'b0;
    start_flag = 1'b0;
    rdy_hold = 0;
    row_typed = 1'b0;
    row_n  = 2'd0;
    none   = stitch(0, 0, KIND_NORMAL, 1'b0);
    row_e0 = none;
    row_e1 = none;
    fin    = stitch(0, 0, KIND_END, 1'b1);
    pair_limit_m = 24'd1;
    clear_parse_m();

    // limit 1 after reset: one stitch then the appended end
    add_typed(8'h05, 1'b1, 2'd0, none, none);
    add_typed(8'h7F, 1'b0, 2'd2, stitch(5, 127, KIND_NORMAL, 1'b0), fin);
    add_typed(8'h00, 1'b0, 2'd0, none, none);
    // zero limit: lone end stitch
    add_cfg(24'd0);
    add_typed(8'h11, 1'b1, 2'd1, fin, none);
    // stop, trims with escape bytes as moves, escape with another code
    add_cfg(24'hFFFFFF);
    add_byte(ESC_BYTE, 1'b1);
    add_byte(8'h01, 1'b0);
    add_byte(ESC_BYTE, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(ESC_BYTE, 1'b0);
    add_byte(TRIM_A, 1'b0);
    add_byte(ESC_BYTE, 1'b0);
    add_byte(TRIM_B, 1'b0);
    add_byte(ESC_BYTE, 1'b0);
    add_byte(TRIM_C, 1'b0);
    add_byte(8'h7F, 1'b0);
    add_byte(ESC_BYTE, 1'b0);
    add_byte(ESC_BYTE, 1'b0);
    add_byte(8'h00, 1'b0);
    // limit lowered below the count between words: next byte gives a lone end stitch
    add_cfg(24'd3);
    add_typed(8'h56, 1'b0, 2'd1, fin, none);
    // escape word uses up the limit; the following word is still read
    add_cfg(24'd1);
    add_byte(ESC_BYTE, 1'b1);
    add_byte(8'h03, 1'b0);
    add_byte(END_CODE, 1'b0);
    add_byte(8'h20, 1'b0);
    // restart mid-word, then the end code
    add_byte(ESC_BYTE, 1'b1);
    add_byte(ESC_BYTE, 1'b1);
    add_typed(END_CODE, 1'b0, 2'd1, fin, none);

    repeat (8) @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        set_limit(plan[i].limit);
      end else begin
        row_typed = plan[i].typed;
        row_n  = plan[i].n;
        row_e0 = plan[i].e0;
        row_e1 = plan[i].e1;
        send_byte(plan[i].b, plan[i].first);
      end
    end
    row_typed = 1'b0;

    mark = useful_bytes;
    while (useful_bytes - mark < RANDOM_BYTES) run_stream();
    s_axis_tvalid = 1'b0;

    while (stitch_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (fails == 0 && stitch_q.size() == 0) begin
      $display("jef_stitch_stream_decoder_core test passed");
    end else begin
      $display("jef_stitch_stream_decoder_core test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/jsd_pkg.sv
rtl/jsd_parser.sv
rtl/jsd_out_queue.sv
rtl/jef_stitch_stream_decoder_core.sv
tb/tb_jef_stitch_stream_decoder_core.sv
